// ===== hdl/rtt_pkg.sv =====
// Package: shared types, constants and functions of the retry timeout request tracker.
package rtt_pkg;
	localparam int SLOTS_DEF = 8;
	localparam int RESULT_CAP = 8;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;

	localparam logic [3:0] SF_RESET = 4'd10;
	localparam logic [15:0] BASE_RESET = 16'd1000;
	localparam logic [2:0] MAXRET_RESET = 3'd3;
	localparam logic [31:0] SEED_RESET = 32'd1;

	typedef enum logic [1:0] {
		ACT_SEND   = 2'd0,
		ACT_ACK    = 2'd1,
		ACT_CANCEL = 2'd2,
		ACT_TICK   = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		EV_XMIT    = 3'd0,
		EV_BUSY    = 3'd1,
		EV_FULL    = 3'd2,
		EV_RETX    = 3'd3,
		EV_ACKED   = 3'd4,
		EV_TIMEOUT = 3'd5,
		EV_CANCEL  = 3'd6
	} event_t;

	typedef enum logic [1:0] {
		REG_SF     = 2'd0,
		REG_BASE   = 2'd1,
		REG_MAXRET = 2'd2,
		REG_SEED   = 2'd3
	} reg_idx_t;

	// controller to datapath commands
	typedef struct packed {
		logic latch_in;     // capture input transaction
		logic scan_clr;     // reset scan index
		logic scan_inc;     // advance scan index
		logic send_claim;   // write new slot fields
		logic ack_write;    // mark matched slot answered
		logic cancel_free;  // free matched slot
		logic tick_dec;     // decrement current slot
		logic tick_hold;    // set countdown to one (cap reached)
		logic tick_done;    // free current slot (acked or timed out)
		logic tick_retx;    // decrement retries of current slot
		logic to_start;     // start timeout computation
		logic to_store;     // store computed timeout in slot
		logic emit;         // drive a result
		logic [2:0] emit_ev;
		logic emit_last;
		logic emit_cur;     // result from scanned slot, else from match/free
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		action_t act;
		logic scan_end;      // scan index at last slot
		logic cur_active;
		logic cur_expired;
		logic cur_answered;
		logic cur_retries_nz;
		logic match_found;
		logic match_seq;
		logic match_waits;
		logic free_found;
		logic to_done;
	} stat_t;

	function automatic logic [5:0] sf_factor(input logic [3:0] sf);
		logic [5:0] f;
		case (sf)
			4'd7:    f = 6'd10;
			4'd8:    f = 6'd14;
			4'd9:    f = 6'd20;
			4'd10:   f = 6'd30;
			4'd11:   f = 6'd44;
			4'd12:   f = 6'd60;
			default: f = 6'd30;
		endcase
		return f;
	endfunction

	// floor(x / 10) by reciprocal multiplication, exact for any 32-bit x
	function automatic logic [31:0] div10(input logic [31:0] x);
		logic [63:0] p;
		p = 64'(x) * 64'(DIV10_MAGIC);
		return {3'b000, p[63:35]};
	endfunction
endpackage

// ===== hdl/rtt_timeout.sv =====
// Timeout unit: scaled base, backoff shift, LFSR jitter with serial modulo.
module rtt_timeout import rtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  sf,
	input  logic [15:0] base,
	input  logic [2:0]  maxret,
	input  logic [2:0]  retries,
	input  logic        seed_load,
	input  logic [31:0] seed,
	input  logic        start,
	output logic        done,
	output logic [31:0] timeout
);
	typedef enum logic [5:0] {
		T_IDLE = 6'b000001,
		T_MUL  = 6'b000010,
		T_DIV  = 6'b000100,
		T_JIT  = 6'b001000,
		T_MOD  = 6'b010000,
		T_OUT  = 6'b100000
	} tstate_t;

	tstate_t state_q;
	logic [31:0] lfsr_q;
	logic [31:0] t_q;
	logic [31:0] j_q;
	logic [31:0] r_q;
	logic [32:0] den_q;
	logic [32:0] rem_q;
	logic [5:0]  bit_q;
	logic [21:0] prod_q;
	logic [2:0]  shift;
	logic [31:0] lfsr_nx;
	logic [32:0] trial;
	logic [31:0] t3;

	assign shift = (maxret >= retries) ? (maxret - retries) : 3'd0;
	assign lfsr_nx = lfsr_q[0] ? ((lfsr_q >> 1) ^ LFSR_TAPS) : (lfsr_q >> 1);
	assign trial = {rem_q[31:0], r_q[bit_q[4:0]]};
	// t_q stays below 2^26, so three times it fits in 32 bits
	assign t3 = {t_q[30:0], 1'b0} + t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			lfsr_q <= SEED_RESET;
		end else begin
			case (state_q)
				T_IDLE: if (start) state_q <= T_MUL;
				T_MUL:  state_q <= T_DIV;
				T_DIV:  state_q <= T_JIT;
				T_JIT:  state_q <= T_MOD;
				T_MOD:  if (bit_q == 6'd0) state_q <= T_OUT;
				T_OUT:  state_q <= T_IDLE;
				default: state_q <= T_IDLE;
			endcase
			if (seed_load) lfsr_q <= seed;
			else if (state_q == T_JIT) lfsr_q <= lfsr_nx;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			T_IDLE: prod_q <= 22'(base) * 22'(sf_factor(sf));
			T_MUL:  t_q <= div10({10'd0, prod_q}) << shift;
			T_DIV:  j_q <= div10(t3);
			T_JIT: begin
				r_q <= lfsr_nx;
				den_q <= {j_q, 1'b1};
				rem_q <= '0;
				bit_q <= 6'd31;
			end
			T_MOD: begin
				rem_q <= (trial >= den_q) ? (trial - den_q) : trial;
				if (bit_q != 6'd0) bit_q <= bit_q - 6'd1;
			end
			T_OUT: ;
			default: ;
		endcase
	end

	assign done = (state_q == T_OUT);
	assign timeout = t_q - j_q + rem_q[31:0];
endmodule

// ===== hdl/rtt_datapath.sv =====
// Datapath: slot table, input capture, matching, scan index and result drive.
module rtt_datapath import rtt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic [1:0]  action,
	input  logic [15:0] node_id,
	input  logic [15:0] seq_num,
	input  logic        blocking,
	input  logic [15:0] ack_status,
	input  logic [3:0]  sf,
	input  logic [15:0] base,
	input  logic [2:0]  maxret,
	input  logic        seed_load,
	input  logic [31:0] seed,
	output logic        strobe,
	output logic [2:0]  event_res,
	output logic [15:0] out_node,
	output logic [4:0]  out_slot,
	output logic [15:0] out_status,
	output logic        last
);
	logic [SLOTS-1:0] active_q;
	logic [15:0] node_q [SLOTS];
	logic [15:0] seq_q [SLOTS];
	logic        waits_q [SLOTS];
	logic [2:0]  retries_q [SLOTS];
	logic        answered_q [SLOTS];
	logic [15:0] result_q [SLOTS];
	logic [31:0] cd_q [SLOTS];

	action_t     act_q;
	logic [15:0] in_node_q, in_seq_q, in_status_q;
	logic        in_blk_q;
	logic [SW-1:0] idx_q;
	logic [SW-1:0] mslot, fslot, tslot_q;
	logic        mfound, ffound;
	logic        to_done;
	logic [31:0] to_val;
	logic [2:0]  to_retries;

	always_comb begin
		mfound = 1'b0;
		mslot = '0;
		ffound = 1'b0;
		fslot = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (active_q[i] && node_q[i] == in_node_q) begin
				mfound = 1'b1;
				mslot = SW'(i);
			end
			if (!active_q[i]) begin
				ffound = 1'b1;
				fslot = SW'(i);
			end
		end
	end

	assign to_retries = retries_q[tslot_q];

	rtt_timeout u_to (
		.clk(clk), .arst_n(arst_n), .sf(sf), .base(base), .maxret(maxret),
		.retries(to_retries), .seed_load(seed_load), .seed(seed),
		.start(cmd.to_start), .done(to_done), .timeout(to_val)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			idx_q <= '0;
			strobe <= 1'b0;
			act_q <= ACT_SEND;
		end else begin
			strobe <= cmd.emit;
			if (cmd.latch_in) act_q <= action_t'(action);
			if (cmd.scan_clr) idx_q <= '0;
			else if (cmd.scan_inc) idx_q <= idx_q + SW'(1);
			if (cmd.send_claim) active_q[fslot] <= 1'b1;
			if (cmd.cancel_free) active_q[mslot] <= 1'b0;
			if (cmd.tick_done) active_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			in_node_q <= node_id;
			in_seq_q <= seq_num;
			in_blk_q <= blocking;
			in_status_q <= ack_status;
		end
		if (cmd.send_claim) begin
			node_q[fslot] <= in_node_q;
			seq_q[fslot] <= in_seq_q;
			waits_q[fslot] <= in_blk_q;
			retries_q[fslot] <= maxret;
			answered_q[fslot] <= 1'b0;
			result_q[fslot] <= '0;
			tslot_q <= fslot;
		end
		if (cmd.ack_write) begin
			answered_q[mslot] <= 1'b1;
			result_q[mslot] <= in_status_q;
		end
		if (cmd.tick_dec) cd_q[idx_q] <= cd_q[idx_q] - 32'd1;
		if (cmd.tick_hold) cd_q[idx_q] <= 32'd1;
		if (cmd.tick_retx) begin
			retries_q[idx_q] <= retries_q[idx_q] - 3'd1;
			tslot_q <= idx_q;
		end
		if (cmd.to_store) cd_q[tslot_q] <= to_val;
		if (cmd.emit) begin
			event_res <= cmd.emit_ev;
			last <= cmd.emit_last;
			out_status <= (cmd.emit_cur && cmd.emit_ev == EV_ACKED) ? result_q[idx_q] : '0;
			if (cmd.emit_cur) begin
				out_node <= node_q[idx_q];
				out_slot <= 5'(idx_q);
			end else begin
				out_node <= in_node_q;
				case (cmd.emit_ev)
					EV_XMIT:  out_slot <= 5'(tslot_q);
					EV_FULL:  out_slot <= '0;
					default:  out_slot <= 5'(mslot);
				endcase
			end
		end
	end

	always_comb begin
		stat.act = act_q;
		stat.scan_end = (idx_q == SW'(SLOTS - 1));
		stat.cur_active = active_q[idx_q];
		stat.cur_expired = (cd_q[idx_q] <= 32'd1);
		stat.cur_answered = answered_q[idx_q];
		stat.cur_retries_nz = (retries_q[idx_q] != 3'd0);
		stat.match_found = mfound;
		stat.match_seq = (seq_q[mslot] == in_seq_q);
		stat.match_waits = waits_q[mslot];
		stat.free_found = ffound;
		stat.to_done = to_done;
	end
endmodule

// ===== hdl/rtt_ctrl.sv =====
// Controller: sequences send, ack, cancel and the tick scan over slots.
module rtt_ctrl import rtt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	input  stat_t stat,
	output cmd_t  cmd
);
	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DEC   = 7'b0000010,
		S_SEND  = 7'b0000100,
		S_SWAIT = 7'b0001000,
		S_SCAN  = 7'b0010000,
		S_TWAIT = 7'b0100000,
		S_NEXT  = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [3:0] n_q, n_d;
	logic [2:0] pev_q, pev_d;

	assign busy = (state_q != S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			n_q <= '0;
			pev_q <= EV_XMIT;
		end else begin
			state_q <= state_d;
			n_q <= n_d;
			pev_q <= pev_d;
		end
	end

	// Tick results leave without last; the result buffer marks the final one
	// once the scan is over.
	always_comb begin
		state_d = state_q;
		n_d = n_q;
		pev_d = pev_q;
		cmd = '0;
		case (state_q)
			S_IDLE: if (start) begin
				cmd.latch_in = 1'b1;
				cmd.scan_clr = 1'b1;
				state_d = S_DEC;
			end
			S_DEC: begin
				n_d = '0;
				case (stat.act)
					ACT_SEND: begin
						cmd.emit_cur = 1'b0;
						if (stat.match_found) begin
							cmd.emit = 1'b1; cmd.emit_ev = EV_BUSY; cmd.emit_last = 1'b1;
							state_d = S_IDLE;
						end else if (!stat.free_found) begin
							cmd.emit = 1'b1; cmd.emit_ev = EV_FULL; cmd.emit_last = 1'b1;
							state_d = S_IDLE;
						end else begin
							cmd.send_claim = 1'b1;
							state_d = S_SEND;
						end
					end
					ACT_ACK: begin
						if (stat.match_found && stat.match_seq) cmd.ack_write = 1'b1;
						state_d = S_IDLE;
					end
					ACT_CANCEL: begin
						if (stat.match_found) begin
							cmd.cancel_free = 1'b1;
							if (stat.match_waits) begin
								cmd.emit = 1'b1; cmd.emit_ev = EV_CANCEL; cmd.emit_last = 1'b1;
							end
						end
						state_d = S_IDLE;
					end
					default: state_d = S_SCAN;
				endcase
			end
			S_SEND: begin
				cmd.to_start = 1'b1;
				state_d = S_SWAIT;
			end
			S_SWAIT: if (stat.to_done) begin
				cmd.to_store = 1'b1;
				cmd.emit = 1'b1; cmd.emit_ev = EV_XMIT; cmd.emit_last = 1'b1;
				state_d = S_IDLE;
			end
			S_SCAN: begin
				if (stat.cur_active && stat.cur_expired && n_q != 4'(RESULT_CAP)) begin
					if (stat.cur_answered) begin
						pev_d = EV_ACKED;
						state_d = S_NEXT;
					end else if (stat.cur_retries_nz) begin
						cmd.tick_retx = 1'b1;
						pev_d = EV_RETX;
						state_d = S_NEXT;
					end else begin
						pev_d = EV_TIMEOUT;
						state_d = S_NEXT;
					end
				end else begin
					if (stat.cur_active && stat.cur_expired) cmd.tick_hold = 1'b1;
					else if (stat.cur_active) cmd.tick_dec = 1'b1;
					if (stat.scan_end) state_d = S_IDLE;
					else cmd.scan_inc = 1'b1;
				end
			end
			S_NEXT: begin
				if (pev_q == EV_RETX) begin
					cmd.to_start = 1'b1;
					state_d = S_TWAIT;
				end else begin
					cmd.tick_done = 1'b1;
					cmd.emit = 1'b1; cmd.emit_ev = pev_q; cmd.emit_cur = 1'b1;
					cmd.emit_last = 1'b0;
					n_d = n_q + 4'd1;
					if (stat.scan_end) state_d = S_IDLE;
					else begin cmd.scan_inc = 1'b1; state_d = S_SCAN; end
				end
			end
			S_TWAIT: if (stat.to_done) begin
				cmd.to_store = 1'b1;
				cmd.emit = 1'b1; cmd.emit_ev = EV_RETX; cmd.emit_cur = 1'b1;
				cmd.emit_last = 1'b0;
				n_d = n_q + 4'd1;
				if (stat.scan_end) state_d = S_IDLE;
				else begin cmd.scan_inc = 1'b1; state_d = S_SCAN; end
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule

// ===== hdl/rtt_last.sv =====
// Result buffer: holds one tick result back to mark the final one.
module rtt_last import rtt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_strobe,
	input  logic [2:0]  in_ev,
	input  logic [15:0] in_node,
	input  logic [4:0]  in_slot,
	input  logic [15:0] in_status,
	input  logic        in_last,
	input  logic        flush,
	output logic        strobe,
	output logic [2:0]  event_res,
	output logic [15:0] out_node,
	output logic [4:0]  out_slot,
	output logic [15:0] out_status,
	output logic        last
);
	logic        hv_q;
	logic [2:0]  hev_q;
	logic [15:0] hnode_q, hstat_q;
	logic [4:0]  hslot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q <= 1'b0;
			strobe <= 1'b0;
			last <= 1'b0;
		end else begin
			if (in_strobe && in_last) begin
				strobe <= 1'b1;
				last <= 1'b1;
				hv_q <= 1'b0;
			end else if (in_strobe) begin
				strobe <= hv_q;
				last <= 1'b0;
				hv_q <= 1'b1;
			end else if (flush && hv_q) begin
				strobe <= 1'b1;
				last <= 1'b1;
				hv_q <= 1'b0;
			end else begin
				strobe <= 1'b0;
				last <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_strobe && in_last) begin
			event_res <= in_ev; out_node <= in_node; out_slot <= in_slot;
			out_status <= in_status;
		end else if (in_strobe) begin
			event_res <= hev_q; out_node <= hnode_q; out_slot <= hslot_q;
			out_status <= hstat_q;
			hev_q <= in_ev; hnode_q <= in_node; hslot_q <= in_slot; hstat_q <= in_status;
		end else if (flush) begin
			event_res <= hev_q; out_node <= hnode_q; out_slot <= hslot_q;
			out_status <= hstat_q;
		end
	end
endmodule

// ===== hdl/retry_timeout_request_tracker_unit.sv =====
// Top level: retry timeout request tracker with configuration registers.
// One transaction at a time; busy is high while it is worked on and stays high
// through the busy_q and busy2_q registers after it, so that the held result can
// leave. Send and retransmit cost is set by the timeout unit: multiply, two
// divides by ten, 32-step serial modulo. Results appear with a strobe for one
// cycle each and cannot be stalled; tick results leave one result later than
// found so that the final one carries last.
module retry_timeout_request_tracker_unit import rtt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [15:0] node_id,
	input  logic [15:0] seq_num,
	input  logic        blocking,
	input  logic signed [15:0] ack_status,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output logic        strobe,
	output logic [2:0]  event_res,
	output logic [15:0] out_node,
	output logic [4:0]  out_slot,
	output logic signed [15:0] out_status,
	output logic        last
);
	logic [3:0]  sf_q;
	logic [15:0] base_q;
	logic [2:0]  maxret_q;
	logic        seed_load;
	cmd_t        cmd;
	stat_t       stat;
	logic        d_strobe, d_last, ctl_busy, busy_q, busy2_q;
	logic [2:0]  d_ev;
	logic [15:0] d_node, d_status;
	logic [4:0]  d_slot;

	assign cfg_ready = 1'b1;
	assign seed_load = cfg_valid && cfg_index == REG_SEED;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= SF_RESET;
			base_q <= BASE_RESET;
			maxret_q <= MAXRET_RESET;
			busy_q <= 1'b0;
			busy2_q <= 1'b0;
		end else begin
			busy_q <= ctl_busy;
			busy2_q <= busy_q;
			if (cfg_valid) begin
				case (reg_idx_t'(cfg_index))
					REG_SF:     sf_q <= cfg_data[3:0];
					REG_BASE:   base_q <= cfg_data[15:0];
					REG_MAXRET: maxret_q <= cfg_data[2:0];
					default: ;
				endcase
			end
		end
	end

	// busy stays high through busy_q and busy2_q to let the held result leave
	assign busy = ctl_busy || busy_q || busy2_q;

	rtt_ctrl u_ctrl (.clk(clk), .arst_n(arst_n), .start(start && !busy), .busy(ctl_busy),
		.stat(stat), .cmd(cmd));

	rtt_datapath #(.SLOTS(SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.action(action), .node_id(node_id), .seq_num(seq_num), .blocking(blocking),
		.ack_status(ack_status), .sf(sf_q), .base(base_q), .maxret(maxret_q),
		.seed_load(seed_load), .seed(cfg_data),
		.strobe(d_strobe), .event_res(d_ev), .out_node(d_node), .out_slot(d_slot),
		.out_status(d_status), .last(d_last)
	);

	rtt_last u_last (
		.clk(clk), .arst_n(arst_n), .in_strobe(d_strobe), .in_ev(d_ev),
		.in_node(d_node), .in_slot(d_slot), .in_status(d_status), .in_last(d_last),
		.flush(!ctl_busy && !busy_q && busy2_q),
		.strobe(strobe), .event_res(event_res), .out_node(out_node),
		.out_slot(out_slot), .out_status(out_status), .last(last)
	);

	a_last_needs_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		last |-> strobe) else $error("last without strobe");
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && event_res != EV_ACKED |-> out_status == '0)
		else $error("status on non-acked event");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ctl_busy) |-> $past(start)) else $error("busy without start");
endmodule
